// ----- rtl/sssd_pkg.sv -----
package sssd_pkg;

    // Pattern store geometry
    localparam int PAT_DEPTH = 256;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);
    localparam int CNT_W     = PAT_AW + 1;

    // Display chain
    localparam int MAX_CHAIN = 4;
    localparam int CH_W      = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int WIN_AW    = CH_W + 3;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Stream and config widths
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int DC_W       = 3;
    localparam int BR_W       = 4;

    // Operation codes on s_tuser
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SETUP  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 1'b1;
    localparam logic [DC_W-1:0]      DC_RESET          = 3'd2;
    localparam logic [BR_W-1:0]      BR_RESET          = 4'd1;

    // Driver command registers
    localparam logic [3:0] CMD_DECODE    = 4'h9;
    localparam logic [3:0] CMD_INTENSITY = 4'ha;
    localparam logic [3:0] CMD_SCAN      = 4'hb;
    localparam logic [3:0] CMD_SHUTDOWN  = 4'hc;
    localparam logic [3:0] CMD_TEST      = 4'hf;
    localparam logic [7:0] SCAN_ALL      = 8'd7;

    // Setup sequence group indexes
    localparam logic [2:0] GRP_SCAN      = 3'd0;
    localparam logic [2:0] GRP_DECODE    = 3'd1;
    localparam logic [2:0] GRP_TEST      = 3'd2;
    localparam logic [2:0] GRP_INTENSITY = 3'd3;
    localparam logic [2:0] GRP_SHUTDOWN  = 3'd4;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_SETUP  = 2'd2
    } cmd_kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic       start_new;
        logic       two;
        logic [7:0] pat0;
        logic [7:0] pat1;
    } cmd_t;

    // ASCII to segment pattern, DP,A..G from bit 7 down; first pattern of M/W
    function automatic logic [7:0] glyph(input logic [7:0] ch);
        logic [7:0] p;
        case (ch)
            8'h41, 8'h61: p = 8'h77;          // A a
            8'h42, 8'h62: p = 8'h1f;          // B b
            8'h43, 8'h63: p = 8'h4e;          // C c
            8'h44, 8'h64: p = 8'h3d;          // D d
            8'h45, 8'h65: p = 8'h4f;          // E e
            8'h46, 8'h66: p = 8'h47;          // F f
            8'h47, 8'h67: p = 8'h7b;          // G g
            8'h48:        p = 8'h37;          // H
            8'h68:        p = 8'h17;          // h
            8'h49, 8'h69: p = 8'h06;          // I i
            8'h4a, 8'h6a: p = 8'h3c;          // J j
            8'h4b, 8'h6b: p = 8'h37;          // K k
            8'h4c, 8'h6c: p = 8'h0e;          // L l
            8'h4d, 8'h6d: p = 8'h66;          // M m, left half
            8'h4e, 8'h6e: p = 8'h15;          // N n
            8'h4f:        p = 8'h7e;          // O
            8'h6f:        p = 8'h1d;          // o
            8'h50, 8'h70: p = 8'h67;          // P p
            8'h51, 8'h71: p = 8'h73;          // Q q
            8'h52, 8'h72: p = 8'h05;          // R r
            8'h53, 8'h73: p = 8'h5b;          // S s
            8'h54, 8'h74: p = 8'h0f;          // T t
            8'h55:        p = 8'h3e;          // U
            8'h75:        p = 8'h1c;          // u
            8'h56, 8'h76: p = 8'h1c;          // V v
            8'h57, 8'h77: p = 8'h1e;          // W w, left half
            8'h58, 8'h78: p = 8'h37;          // X x
            8'h59, 8'h79: p = 8'h3b;          // Y y
            8'h5a, 8'h7a: p = 8'h6d;          // Z z
            8'h30:        p = 8'h7e;
            8'h31:        p = 8'h30;
            8'h32:        p = 8'h6d;
            8'h33:        p = 8'h79;
            8'h34:        p = 8'h33;
            8'h35:        p = 8'h5b;
            8'h36:        p = 8'h5f;
            8'h37:        p = 8'h70;
            8'h38:        p = 8'h7f;
            8'h39:        p = 8'h7b;
            8'h2e:        p = 8'h80;          // period
            8'h2d:        p = 8'h01;          // dash
            default:      p = 8'h00;          // space and anything unknown
        endcase
        return p;
    endfunction

    // Right half of the wide letters
    function automatic logic [7:0] glyph_right(input logic [7:0] ch);
        logic [7:0] p;
        case (ch)
            8'h4d, 8'h6d: p = 8'h72;
            8'h57, 8'h77: p = 8'h3c;
            default:      p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic is_wide(input logic [7:0] ch);
        return (ch == 8'h4d) || (ch == 8'h6d) || (ch == 8'h57) || (ch == 8'h77);
    endfunction

    function automatic logic [3:0] setup_addr(input logic [2:0] grp);
        logic [3:0] a;
        case (grp)
            GRP_SCAN:      a = CMD_SCAN;
            GRP_DECODE:    a = CMD_DECODE;
            GRP_TEST:      a = CMD_TEST;
            GRP_INTENSITY: a = CMD_INTENSITY;
            GRP_SHUTDOWN:  a = CMD_SHUTDOWN;
            default:       a = CMD_SHUTDOWN;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] setup_data(input logic [2:0] grp,
                                              input logic [BR_W-1:0] br);
        logic [7:0] d;
        case (grp)
            GRP_SCAN:      d = SCAN_ALL;
            GRP_DECODE:    d = 8'd0;
            GRP_TEST:      d = 8'd0;
            GRP_INTENSITY: d = 8'(br);
            GRP_SHUTDOWN:  d = 8'd1;
            default:       d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/seven_segment_scroll_driver_core.sv -----
// Append: written in ST_IDLE (right half of M and W in ST_APPEND2), once the beat has
// passed the front register and the command queue. Tick: dispatch, then walk the pattern
// store into the window buffer (one memory read port), then 8*N words at one per cycle
// while m_tready holds, N = chained displays.
// Setup: 5*N words, one per cycle unless m_tready stalls; also after any tick that wraps.
// Reset (aresetn low, synchronous) clears counts, position and handshakes, not the store.
module seven_segment_scroll_driver_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sssd_pkg::S_TDATA_W-1:0]     s_tdata,    // char_code[7:0], start_new[8]
    input  logic [sssd_pkg::S_TUSER_W-1:0]     s_tuser,    // operation[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sssd_pkg::M_TDATA_W-1:0]     m_tdata,    // reg_address[3:0],
                                                           // reg_data[11:4], latch_after[12]
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [sssd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sssd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sssd_pkg::*;

    logic [DC_W-1:0] dc_reg, dc_next;
    logic [BR_W-1:0] br_reg, br_next;

    cmd_t front_cmd, queue_cmd;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    // Config registers
    always_comb begin
        dc_next = dc_reg;
        br_next = br_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DISPLAY_COUNT: dc_next = cfg_wdata[DC_W-1:0];
                CFG_BRIGHTNESS:    br_next = cfg_wdata[BR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg <= DC_RESET;
            br_reg <= BR_RESET;
        end else begin
            dc_reg <= dc_next;
            br_reg <= br_next;
        end
    end

    sssd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    sssd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    sssd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (queue_valid),
        .cmd_ready     (queue_ready),
        .cmd           (queue_cmd),
        .display_count (dc_reg),
        .brightness    (br_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// ----- rtl/sssd_front.sv -----
module sssd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sssd_pkg::S_TDATA_W-1:0]       s_tdata,   // char_code[7:0], start_new[8]
    input  logic [sssd_pkg::S_TUSER_W-1:0]       s_tuser,   // operation[1:0]
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output sssd_pkg::cmd_t                       cmd
);
    import sssd_pkg::*;

    logic       cmd_valid_reg, cmd_valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] ch;
    logic       accept;

    assign ch        = s_tdata[7:0];
    assign s_tready  = !cmd_valid_reg || cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // Classify the beat; unused opcode is swallowed here
    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (accept) begin
            cmd_next.start_new = s_tdata[8];
            cmd_next.pat0      = glyph(ch);
            cmd_next.pat1      = glyph_right(ch);
            cmd_next.two       = is_wide(ch);
            cmd_valid_next     = 1'b1;
            case (s_tuser)
                OP_APPEND: cmd_next.kind = KIND_APPEND;
                OP_TICK:   cmd_next.kind = KIND_TICK;
                OP_SETUP:  cmd_next.kind = KIND_SETUP;
                default: begin
                    cmd_next.kind  = KIND_SETUP;
                    cmd_valid_next = 1'b0;
                end
            endcase
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

// ----- rtl/sssd_fifo.sv -----
module sssd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sssd_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output sssd_pkg::cmd_t out_cmd
);
    import sssd_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push, pop;

    assign in_ready  = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : QUEUE_AW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : QUEUE_AW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = QUEUE_CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = QUEUE_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_fifo_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue overfilled");
`endif

endmodule

// ----- rtl/sssd_back.sv -----
module sssd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  sssd_pkg::cmd_t                cmd,
    input  logic [sssd_pkg::DC_W-1:0]     display_count,
    input  logic [sssd_pkg::BR_W-1:0]     brightness,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sssd_pkg::M_TDATA_W-1:0] m_tdata,  // reg_address[3:0], reg_data[11:4],
                                                      // latch_after[12]
    output logic                          m_tlast
);
    import sssd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_APPEND2 = 5'b00010,
        ST_FILL    = 5'b00100,
        ST_EMIT    = 5'b01000,
        ST_SETUP   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PAT_AW-1:0]   start_reg, start_next;
    logic [PAT_AW-1:0]   ptr_reg, ptr_next;
    logic [WIN_AW-1:0]   fill_reg, fill_next;
    logic [2:0]          row_reg, row_next;
    logic [CH_W-1:0]     disp_reg, disp_next;
    logic [2:0]          grp_reg, grp_next;
    logic [7:0]          pend_reg, pend_next;
    logic                setup_after_reg, setup_after_next;
    logic                empty_reg, empty_next;

    // Pattern store and window buffer
    logic [7:0]          store_mem [PAT_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                rd_v_reg;
    logic [WIN_AW-1:0]   rd_k_reg;
    logic [7:0]          window_reg [WIN_DEPTH];

    logic                wr_en;
    logic [PAT_AW-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                rd_issue;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_addr_reg, out_addr_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_latch_reg, out_latch_next;
    logic                out_last_reg, out_last_next;

    logic                adv, load;
    logic [CH_W-1:0]     chain_m1;
    logic [CNT_W-1:0]    base, inc;
    logic                set_latch;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_latch_reg, out_data_reg, out_addr_reg};
    assign m_tlast   = out_last_reg;
    assign adv       = !out_valid_reg || m_tready;
    assign cmd_ready = state_reg == ST_IDLE;
    assign set_latch = disp_reg == chain_m1;

    // Clamp the chain length to 1..MAX_CHAIN, kept as length minus one
    always_comb begin
        if (display_count == '0) begin
            chain_m1 = '0;
        end else if (display_count > DC_W'(MAX_CHAIN)) begin
            chain_m1 = CH_W'(MAX_CHAIN - 1);
        end else begin
            chain_m1 = CH_W'(display_count - 1'b1);
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        start_next       = start_reg;
        ptr_next         = ptr_reg;
        fill_next        = fill_reg;
        row_next         = row_reg;
        disp_next        = disp_reg;
        grp_next         = grp_reg;
        pend_next        = pend_reg;
        setup_after_next = setup_after_reg;
        empty_next       = empty_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[PAT_AW-1:0];
        wr_data          = pend_reg;
        rd_issue         = 1'b0;
        load             = 1'b0;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_latch_next   = out_latch_reg;
        out_last_next    = out_last_reg;
        base             = count_reg;
        inc              = CNT_W'({1'b0, start_reg} + 1'b1);

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        KIND_APPEND: begin
                            if (cmd.start_new) begin
                                base       = '0;
                                start_next = '0;
                            end
                            count_next = base;
                            if (base < CNT_W'(PAT_DEPTH)) begin
                                wr_en      = 1'b1;
                                wr_addr    = base[PAT_AW-1:0];
                                wr_data    = cmd.pat0;
                                count_next = CNT_W'(base + 1'b1);
                            end
                            pend_next = cmd.pat1;
                            if (cmd.two) begin
                                state_next = ST_APPEND2;
                            end
                        end
                        KIND_TICK: begin
                            ptr_next   = start_reg;
                            fill_next  = '0;
                            empty_next = count_reg == '0;
                            // advance scroll position now, window walk uses ptr
                            if (inc >= count_reg) begin
                                start_next       = '0;
                                setup_after_next = 1'b1;
                            end else begin
                                start_next       = inc[PAT_AW-1:0];
                                setup_after_next = 1'b0;
                            end
                            state_next = ST_FILL;
                        end
                        KIND_SETUP: begin
                            grp_next   = GRP_SCAN;
                            disp_next  = '0;
                            state_next = ST_SETUP;
                        end
                        default: ;
                    endcase
                end
            end

            ST_APPEND2: begin
                if (count_reg < CNT_W'(PAT_DEPTH)) begin
                    wr_en      = 1'b1;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
                state_next = ST_IDLE;
            end

            // Walk the store once per window entry, wrapping at the count
            ST_FILL: begin
                rd_issue = 1'b1;
                inc      = CNT_W'({1'b0, ptr_reg} + 1'b1);
                ptr_next = (inc == count_reg) ? '0 : inc[PAT_AW-1:0];
                fill_next = WIN_AW'(fill_reg + 1'b1);
                if (fill_reg == {chain_m1, 3'b111}) begin
                    row_next   = '0;
                    disp_next  = chain_m1;
                    state_next = ST_EMIT;
                end
            end

            // Rows 0..7, farthest display first, latch after display 0
            ST_EMIT: begin
                if (adv) begin
                    load           = 1'b1;
                    out_addr_next  = 4'd8 - {1'b0, row_reg};
                    out_data_next  = window_reg[{disp_reg, row_reg}];
                    out_latch_next = disp_reg == '0;
                    out_last_next  = (row_reg == 3'd7) && (disp_reg == '0)
                                   && !setup_after_reg;
                    if (disp_reg == '0) begin
                        disp_next = chain_m1;
                        row_next  = 3'(row_reg + 1'b1);
                        if (row_reg == 3'd7) begin
                            grp_next   = GRP_SCAN;
                            disp_next  = '0;
                            state_next = setup_after_reg ? ST_SETUP : ST_IDLE;
                        end
                    end else begin
                        disp_next = CH_W'(disp_reg - 1'b1);
                    end
                end
            end

            // Five groups, each one word per display
            ST_SETUP: begin
                if (adv) begin
                    load           = 1'b1;
                    out_addr_next  = setup_addr(grp_reg);
                    out_data_next  = setup_data(grp_reg, brightness);
                    out_latch_next = set_latch;
                    out_last_next  = set_latch && (grp_reg == GRP_SHUTDOWN);
                    if (set_latch) begin
                        disp_next = '0;
                        grp_next  = 3'(grp_reg + 1'b1);
                        if (grp_reg == GRP_SHUTDOWN) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        disp_next = CH_W'(disp_reg + 1'b1);
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase

        out_valid_next = adv ? load : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        fill_reg        <= fill_next;
        row_reg         <= row_next;
        disp_reg        <= disp_next;
        grp_reg         <= grp_next;
        pend_reg        <= pend_next;
        setup_after_reg <= setup_after_next;
        empty_reg       <= empty_next;
        out_addr_reg    <= out_addr_next;
        out_data_reg    <= out_data_next;
        out_latch_reg   <= out_latch_next;
        out_last_reg    <= out_last_next;
        rd_k_reg        <= fill_reg;
    end

    // Pattern store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            rd_data_reg <= store_mem[ptr_reg];
        end
    end

    // Window buffer, blank when the store is empty
    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            window_reg[rd_k_reg] <= empty_reg ? 8'h00 : rd_data_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PAT_DEPTH))
        else $error("pattern count beyond store depth");

    a_start_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 && start_reg == '0) || ({1'b0, start_reg} < count_reg))
        else $error("scroll position outside stored text");

    a_last_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_latch_reg)
        else $error("final word of a burst without latch");
`endif

endmodule

// ----- sim/sssd_scroll_checker.sv -----
// Watches both streams and the register port, predicts the command words of the
// scroll driver and compares every output beat against the oldest word owed.
module sssd_scroll_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sssd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [sssd_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sssd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [sssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sssd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               fail_count,
    output int                               pending,
    output int                               words_seen
);
    import sssd_pkg::*;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       latch;
        logic       last;
    } seg_cmd_t;

    // Shadow copy of the display state
    logic [7:0]       pat_mem [0:PAT_DEPTH-1];
    logic [CNT_W-1:0] pat_cnt;
    logic [PAT_AW-1:0] start_pos;
    logic [DC_W-1:0]  disp_cnt;
    logic [BR_W-1:0]  bright;

    seg_cmd_t owed_words [$];
    seg_cmd_t want, got;
    int       n_fail = 0;
    int       n_words = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
        words_seen = 0;
    end

    // Segment pattern of a narrow character, DP,A..G from bit 7 down
    function automatic logic [7:0] segments_for(input logic [7:0] ch);
        case (ch)
            "A", "a": return 8'h77;
            "B", "b": return 8'h1f;
            "C", "c": return 8'h4e;
            "D", "d": return 8'h3d;
            "E", "e": return 8'h4f;
            "F", "f": return 8'h47;
            "G", "g", "9": return 8'h7b;
            "H", "K", "k", "X", "x": return 8'h37;
            "h": return 8'h17;
            "I", "i": return 8'h06;
            "J", "j": return 8'h3c;
            "L", "l": return 8'h0e;
            "N", "n": return 8'h15;
            "O", "0": return 8'h7e;
            "o": return 8'h1d;
            "P", "p": return 8'h67;
            "Q", "q": return 8'h73;
            "R", "r": return 8'h05;
            "S", "s", "5": return 8'h5b;
            "T", "t": return 8'h0f;
            "U": return 8'h3e;
            "u", "V", "v": return 8'h1c;
            "Y", "y": return 8'h3b;
            "Z", "z", "2": return 8'h6d;
            "1": return 8'h30;
            "3": return 8'h79;
            "4": return 8'h33;
            "6": return 8'h5f;
            "7": return 8'h70;
            "8": return 8'h7f;
            ".": return 8'h80;
            "-": return 8'h01;
            default: return 8'h00;
        endcase
    endfunction

    // Zero counts as one display, anything past the chain limit is clamped
    function automatic int chain_len();
        if (disp_cnt == 0) return 1;
        if (disp_cnt > MAX_CHAIN) return MAX_CHAIN;
        return int'(disp_cnt);
    endfunction

    task automatic store_pattern(input logic [7:0] p);
        if (pat_cnt < PAT_DEPTH) begin
            pat_mem[pat_cnt[PAT_AW-1:0]] = p;
            pat_cnt = pat_cnt + 1'b1;
        end
    endtask

    task automatic owe_word(input logic [3:0] a, input logic [7:0] d, input logic l);
        seg_cmd_t w;
        w.addr  = a;
        w.data  = d;
        w.latch = l;
        w.last  = 1'b0;
        owed_words.push_back(w);
    endtask

    // One word per display, latch on the last of the group
    task automatic owe_group(input logic [3:0] cmd, input logic [7:0] d);
        int n;
        n = chain_len();
        for (int i = 0; i < n; i++)
            owe_word(cmd, d, i == n - 1);
    endtask

    task automatic owe_setup_words();
        owe_group(CMD_SCAN, SCAN_ALL);
        owe_group(CMD_DECODE, 8'd0);
        owe_group(CMD_TEST, 8'd0);
        owe_group(CMD_INTENSITY, {4'd0, bright});
        owe_group(CMD_SHUTDOWN, 8'd1);
    endtask

    // Window snapshot, advance, then rows with the farthest display first
    task automatic owe_tick_words();
        logic [7:0] win [0:8*MAX_CHAIN-1];
        int         n;
        n = chain_len();
        for (int k = 0; k < 8 * n; k++)
            win[k] = (pat_cnt == 0) ? 8'h00
                   : pat_mem[(int'(start_pos) + k) % int'(pat_cnt)];
        if (int'(start_pos) + 1 >= int'(pat_cnt))
            start_pos = '0;
        else
            start_pos = start_pos + 1'b1;
        for (int row = 0; row < 8; row++)
            for (int i = n - 1; i >= 0; i--)
                owe_word(4'(8 - row), win[row + 8 * i], i == 0);
        if (start_pos == 0)
            owe_setup_words();
    endtask

    task automatic accept_beat(input logic [1:0] op, input logic [7:0] ch, input logic sn);
        int       owed_prior;
        seg_cmd_t w;
        owed_prior = owed_words.size();
        case (op)
            OP_APPEND: begin
                if (sn) begin
                    pat_cnt   = '0;
                    start_pos = '0;
                end
                if (ch == "M" || ch == "m") begin
                    store_pattern(8'h66);
                    store_pattern(8'h72);
                end else if (ch == "W" || ch == "w") begin
                    store_pattern(8'h1e);
                    store_pattern(8'h3c);
                end else begin
                    store_pattern(segments_for(ch));
                end
            end
            OP_TICK:  owe_tick_words();
            OP_SETUP: owe_setup_words();
            default: ;
        endcase
        // mark the final word this beat caused
        if (owed_words.size() > owed_prior) begin
            w = owed_words.pop_back();
            w.last = 1'b1;
            owed_words.push_back(w);
        end
    endtask

    task automatic note_mismatch(input string what, input logic have_want);
        n_fail++;
        if (n_fail <= 10) begin
            if (have_want) begin
                $write("[%0t] %s: expected addr=%h data=%h latch=%b last=%b,",
                       $realtime, what, want.addr, want.data, want.latch, want.last);
                $display(" got addr=%h data=%h latch=%b last=%b pad=%b",
                         got.addr, got.data, got.latch, got.last, m_tdata[15:13]);
            end else begin
                $display("[%0t] %s: nothing expected, got addr=%h data=%h latch=%b last=%b",
                         $realtime, what, got.addr, got.data, got.latch, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_cnt   = '0;
            start_pos = '0;
            disp_cnt  = DC_RESET;
            bright    = BR_RESET;
            owed_words.delete();
        end else begin
            // output beat against the oldest owed word
            if (m_tvalid && m_tready) begin
                n_words++;
                got.addr  = m_tdata[3:0];
                got.data  = m_tdata[11:4];
                got.latch = m_tdata[12];
                got.last  = m_tlast;
                if (owed_words.size() == 0) begin
                    note_mismatch("unexpected word", 1'b0);
                end else begin
                    want = owed_words.pop_front();
                    if (got.addr != want.addr || got.data != want.data ||
                        got.latch != want.latch || got.last != want.last ||
                        m_tdata[15:13] != 3'b000)
                        note_mismatch("word mismatch", 1'b1);
                end
            end
            // input beat
            if (s_tvalid && s_tready)
                accept_beat(s_tuser, s_tdata[7:0], s_tdata[8]);
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DISPLAY_COUNT: disp_cnt = cfg_wdata[DC_W-1:0];
                    CFG_BRIGHTNESS:    bright   = cfg_wdata[BR_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count <= n_fail;
        pending    <= owed_words.size();
        words_seen <= n_words;
    end

endmodule

// ----- sim/tb_top.sv -----
// Stimulus and verdict for the scroll driver; checking lives in the checker.
module tb_top;
    import sssd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_GOAL    = 430;
    localparam int N_PHASES     = 7;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // char_code[7:0], start_new[8]
    logic [S_TUSER_W-1:0]  s_tuser;   // operation[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // reg_address[3:0], reg_data[11:4], latch_after[12]
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int words_seen;

    int    beats_sent = 0;
    int    cycles = 0;
    bit    s_calm = 0;
    bit    r_calm = 0;
    bit    hold_req = 0;
    string charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 .-";

    // Settings per phase; the first one is the reset value and is not written
    int dc_plan [0:N_PHASES-1] = '{2, 1, 4, 0, 7, 3, 2};
    int br_plan [0:N_PHASES-1] = '{1, 0, 15, 7, 12, 5, 9};

    seven_segment_scroll_driver_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sssd_scroll_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .words_seen (words_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches, one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 24) == 0) r_calm = !r_calm;
                stall = r_calm ? 0 : $urandom_range(0, 5);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // Offer one beat after a random gap and wait for it to be taken
    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch, input logic sn);
        int gap;
        if ($urandom_range(0, 19) == 0) s_calm = !s_calm;
        gap = s_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, sn, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_UNUSED) beats_sent++;
    endtask

    // Stop offering, let owed words arrive and the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input int dc, input int br);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DISPLAY_COUNT;
        cfg_wdata <= CFG_DATA_W'(dc);
        @(posedge aclk);
        cfg_index <= CFG_BRIGHTNESS;
        cfg_wdata <= CFG_DATA_W'(br);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly printable text, sometimes any byte
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 7)
            return charset[$urandom_range(0, charset.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_wide();
        case ($urandom_range(0, 3))
            0: return "M";
            1: return "m";
            2: return "W";
            default: return "w";
        endcase
    endfunction

    // Either a text load followed by ticks (with an occasional setup), or a short burst of noise
    task automatic run_phrase();
        int len;
        int ticks;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4))
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end else begin
            len = $urandom_range(1, 12);
            send_beat(OP_APPEND, pick_char(), $urandom_range(0, 3) != 0);
            repeat (len - 1) send_beat(OP_APPEND, pick_char(), 1'b0);
            ticks = $urandom_range(1, len + 3);
            repeat (ticks) begin
                if ($urandom_range(0, 7) == 0) send_beat(OP_SETUP, pick_char(), 1'b0);
                send_beat(OP_TICK, pick_char(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_APPEND;
        cfg_we    = 1'b0;
        cfg_index = CFG_DISPLAY_COUNT;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-store tick, setup, unused op, odd glyphs, start-new
        send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_SETUP, 8'hff, 1'b1);
        send_beat(OP_UNUSED, 8'ha5, 1'b1);
        send_beat(OP_APPEND, "H", 1'b1);
        send_beat(OP_APPEND, "h", 1'b0);
        send_beat(OP_APPEND, "o", 1'b0);
        send_beat(OP_APPEND, "u", 1'b0);
        send_beat(OP_APPEND, "M", 1'b0);
        send_beat(OP_APPEND, "m", 1'b0);
        send_beat(OP_APPEND, "W", 1'b0);
        send_beat(OP_APPEND, "w", 1'b0);
        send_beat(OP_APPEND, 8'hff, 1'b0);
        send_beat(OP_APPEND, 8'h80, 1'b0);
        send_beat(OP_APPEND, 8'h7f, 1'b0);
        send_beat(OP_APPEND, 8'h00, 1'b0);
        send_beat(OP_APPEND, ".", 1'b0);
        send_beat(OP_APPEND, "-", 1'b0);
        send_beat(OP_APPEND, " ", 1'b0);
        send_beat(OP_APPEND, "9", 1'b0);
        repeat (3) send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_APPEND, "w", 1'b1);
        repeat (2) send_beat(OP_TICK, 8'h00, 1'b0);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_settings(dc_plan[p], br_plan[p]);
            end
            // full chain: overfill the store, then back-pressure a run of ticks
            if (p == 2) begin
                send_beat(OP_APPEND, pick_wide(), 1'b1);
                repeat (139) send_beat(OP_APPEND, pick_wide(), 1'b0);
                hold_req = 1;
                repeat (6) send_beat(OP_TICK, pick_char(), 1'b0);
            end
            while (beats_sent < ITEM_GOAL * (p + 1) / N_PHASES)
                run_phrase();
        end

        settle();
        $display("covered %0d input beats over %0d register settings (chain 0..7, brightness 0..15)",
                 beats_sent, N_PHASES);
        $display("%0d command words checked, %0d mismatches", words_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
